[hw/rtl/ipwb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ipwb_pkg;

	typedef enum logic [2:0] {
		MODE_BAN   = 3'd0,
		MODE_UNBAN = 3'd1,
		MODE_CHECK = 3'd2,
		MODE_TICK  = 3'd3,
		MODE_PURGE = 3'd4
	} mode_t;

	localparam logic [31:0] END_PERMANENT = 32'hFFFF_FFFF;
	localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFE;

	localparam logic [31:0] LOW24_MASK = 32'h00FF_FFFF;
	localparam logic [31:0] LOW16_MASK = 32'h0000_FFFF;
	localparam logic [31:0] LOW8_MASK  = 32'h0000_00FF;
	localparam logic [31:0] KEEP_TOP8  = 32'hFF00_0000;
	localparam logic [31:0] KEEP_TOP16 = 32'hFFFF_0000;
	localparam logic [31:0] KEEP_TOP24 = 32'hFFFF_FF00;
	localparam logic [31:0] KEEP_ALL   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] address;
		logic [31:0] duration;
		logic        from_master;
	} cmd_t;

	typedef struct packed {
		logic        allowed;
		logic        found;
		logic [31:0] match_address;
		logic [31:0] match_end_time;
		logic        match_from_master;
		logic        table_full;
	} rsp_t;

	typedef struct packed {
		logic [31:0] pattern;
		logic [31:0] end_time;
		logic        origin;
	} entry_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, TIME_MAX}) ? TIME_MAX : s[31:0];
	endfunction

	// trailing all-ones octets of the pattern are wildcards
	function automatic logic pattern_hits(input logic [31:0] pat, input logic [31:0] addr);
		logic [31:0] keep;
		if ((pat & LOW24_MASK) == LOW24_MASK) begin
			keep = KEEP_TOP8;
		end else if ((pat & LOW16_MASK) == LOW16_MASK) begin
			keep = KEEP_TOP16;
		end else if ((pat & LOW8_MASK) == LOW8_MASK) begin
			keep = KEEP_TOP24;
		end else begin
			keep = KEEP_ALL;
		end
		return (pat & keep) == (addr & keep);
	endfunction

endpackage

`default_nettype wire

[hw/rtl/ipwb_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ipwb_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/ip_wildcard_ban_table.sv]
`timescale 1ns / 1ps
`default_nettype none

// Ordered IPv4 ban table with trailing-octet wildcards. One command is taken at a
// time on cmd; exactly one result follows on res, and cmd is not ready until that
// result transfer completes. Ban, unban, check and purge walk the stored entries
// through a single entry memory, one entry per cycle with a registered read; the
// result is posted once the walk ends (ban stops early at an equal entry).
// Unban, purge and check compact the table in place during the same walk, check
// dropping expired entries before matching.
// Tick and unused modes answer in the next cycle. No clearing pass is needed after reset.
module ip_wildcard_ban_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	ipwb_stream_if.sink   cmd,
	ipwb_stream_if.source res
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t             state_q;
	ipwb_pkg::cmd_t     cmd_q;
	logic [31:0]        end_q;
	logic [31:0]        time_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      rd_q;
	logic [CW-1:0]      wr_q;
	logic               vld_s1;
	logic [AW-1:0]      idx_s1;
	ipwb_pkg::entry_t   rdata_s1;
	logic               hit_q;
	logic               drop_any_q;
	ipwb_pkg::entry_t   match_q;
	ipwb_pkg::rsp_t     rsp_q;

	ipwb_pkg::entry_t   mem [TABLE_DEPTH];

	logic               run;
	logic               is_ban;
	logic               issue;
	logic               done;
	logic               drop;
	logic               ban_eq;
	logic               hits;
	logic [31:0]        sum_c;
	logic               we;
	logic [AW-1:0]      waddr;
	ipwb_pkg::entry_t   wdata;
	ipwb_pkg::entry_t   new_entry;
	ipwb_pkg::rsp_t     rsp_c;

	assign cmd.ready = (state_q == S_IDLE);
	assign res.valid = (state_q == S_OUT);
	assign res.data  = rsp_q;

	assign sum_c  = ipwb_pkg::sat_add(time_q, cmd.data.duration);
	assign run    = (state_q == S_RUN);
	assign is_ban = (cmd_q.mode == ipwb_pkg::MODE_BAN);
	assign issue  = run && (rd_q < cnt_q) && !(is_ban && hit_q);
	assign done   = run && !issue && !vld_s1;
	assign ban_eq = (rdata_s1.pattern == cmd_q.address);
	assign hits   = ipwb_pkg::pattern_hits(rdata_s1.pattern, cmd_q.address);

	assign new_entry = '{pattern: cmd_q.address, end_time: end_q, origin: cmd_q.from_master};

	always_comb begin
		case (cmd_q.mode)
			ipwb_pkg::MODE_UNBAN: drop = ban_eq;
			ipwb_pkg::MODE_PURGE: drop = (rdata_s1.origin == cmd_q.from_master);
			ipwb_pkg::MODE_CHECK: drop = (rdata_s1.end_time != ipwb_pkg::END_PERMANENT) &&
				(rdata_s1.end_time <= time_q);
			default:              drop = 1'b0;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = wr_q[AW-1:0];
		wdata = rdata_s1;
		if (run && vld_s1) begin
			if (is_ban) begin
				if (!hit_q && ban_eq) begin
					we    = 1'b1;
					waddr = idx_s1;
					wdata = new_entry;
				end
			end else if (!drop) begin
				we = 1'b1;
			end
		end else if (done && is_ban && !hit_q && (cnt_q < DEPTH_C)) begin
			we    = 1'b1;
			waddr = cnt_q[AW-1:0];
			wdata = new_entry;
		end
	end

	always_comb begin
		rsp_c = '0;
		case (cmd_q.mode)
			ipwb_pkg::MODE_BAN: begin
				rsp_c.found      = hit_q;
				rsp_c.table_full = !hit_q && (cnt_q == DEPTH_C);
			end
			ipwb_pkg::MODE_UNBAN: begin
				rsp_c.found = drop_any_q;
			end
			ipwb_pkg::MODE_CHECK: begin
				rsp_c.allowed = !hit_q;
				rsp_c.found   = hit_q;
				if (hit_q) begin
					rsp_c.match_address     = match_q.pattern;
					rsp_c.match_end_time    = match_q.end_time;
					rsp_c.match_from_master = match_q.origin;
				end
			end
			default: begin
				rsp_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[rd_q[AW-1:0]];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd.valid) begin
			cmd_q <= cmd.data;
			end_q <= (cmd.data.duration == '0) ? ipwb_pkg::END_PERMANENT : sum_c;
			if (cmd.data.mode == ipwb_pkg::MODE_BAN || cmd.data.mode == ipwb_pkg::MODE_UNBAN ||
				cmd.data.mode == ipwb_pkg::MODE_CHECK || cmd.data.mode == ipwb_pkg::MODE_PURGE) begin
				rsp_q <= rsp_q;
			end else begin
				rsp_q <= '0;
			end
		end
		idx_s1 <= rd_q[AW-1:0];
		if (run && vld_s1 && !is_ban && !drop && !hit_q && hits &&
			cmd_q.mode == ipwb_pkg::MODE_CHECK) begin
			match_q <= rdata_s1;
		end
		if (done) begin
			rsp_q <= rsp_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			time_q     <= '0;
			cnt_q      <= '0;
			rd_q       <= '0;
			wr_q       <= '0;
			vld_s1     <= 1'b0;
			hit_q      <= 1'b0;
			drop_any_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						rd_q       <= '0;
						wr_q       <= '0;
						vld_s1     <= 1'b0;
						hit_q      <= 1'b0;
						drop_any_q <= 1'b0;
						if (cmd.data.mode == ipwb_pkg::MODE_BAN ||
							cmd.data.mode == ipwb_pkg::MODE_UNBAN ||
							cmd.data.mode == ipwb_pkg::MODE_CHECK ||
							cmd.data.mode == ipwb_pkg::MODE_PURGE) begin
							state_q <= S_RUN;
						end else begin
							if (cmd.data.mode == ipwb_pkg::MODE_TICK) begin
								time_q <= sum_c;
							end
							state_q <= S_OUT;
						end
					end
				end
				S_RUN: begin
					vld_s1 <= issue;
					if (issue) begin
						rd_q <= rd_q + CW'(1);
					end
					if (vld_s1) begin
						if (is_ban) begin
							if (!hit_q && ban_eq) begin
								hit_q <= 1'b1;
							end
						end else if (drop) begin
							drop_any_q <= 1'b1;
						end else begin
							wr_q <= wr_q + CW'(1);
							if (cmd_q.mode == ipwb_pkg::MODE_CHECK && !hit_q && hits) begin
								hit_q <= 1'b1;
							end
						end
					end
					if (done) begin
						if (is_ban) begin
							if (!hit_q && (cnt_q < DEPTH_C)) begin
								cnt_q <= cnt_q + CW'(1);
							end
						end else begin
							cnt_q <= wr_q;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("entry count above table depth");

	a_write_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		wr_q <= rd_q)
		else $error("compaction write pointer passed read pointer");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.table_full) |-> (cnt_q == DEPTH_C))
		else $error("table_full reported with free entries");

	a_allowed_excl_found: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.data.allowed && res.data.found))
		else $error("allowed and found both set");

endmodule

`default_nettype wire
